// ===== hw/rtl/vlmra_pkg.sv =====
// Package for the variable-length message ring allocator.
// Holds the sizes, operation codes, request/result structs and controller types.
// No dependencies; every other file but vlmra_ram refers to it by scoped names.
package vlmra_pkg;

  localparam int BufferBytes = 128;
  localparam int OffW        = $clog2(BufferBytes);
  localparam int PosW        = OffW + 2;
  localparam int HdrBytes    = 4;
  localparam int LenW        = 8;
  localparam int TypeW       = 8;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] event_type;
    logic [6:0] payload_bytes;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] payload_offset;
    logic [6:0] oldest_payload_offset;
    logic [7:0] active_type;
    logic       queue_empty;
    logic [5:0] pending_count;
    logic [7:0] bytes_used;
    logic [5:0] peak_pending;
    logic [7:0] peak_bytes_used;
    logic [7:0] missed_count;
  } out_t;

  // Header fields kept per message start (link kept in a store of its own).
  typedef struct packed {
    logic [TypeW-1:0] msg_type;
    logic [LenW-1:0]  length;
  } meta_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StExec,
    StLoad,
    StOut
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_load;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/vlmra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the header stores of the allocator.
module vlmra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/vlmra_ctrl.sv =====
// Sequencer of the message ring allocator: request handshake and step control.
// Depends on vlmra_pkg.
module vlmra_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_stall_i,
  input  vlmra_pkg::ctrl_sts_t  sts_i,
  output vlmra_pkg::ctrl_cmd_t  cmd_o,
  output logic                  in_stall_o,
  output logic                  out_valid_o
);

  vlmra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vlmra_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      vlmra_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = vlmra_pkg::StRead;
        end
      end
      vlmra_pkg::StRead: state_d = vlmra_pkg::StExec;
      vlmra_pkg::StExec: begin
        state_d = sts_i.need_load ? vlmra_pkg::StLoad : vlmra_pkg::StOut;
      end
      vlmra_pkg::StLoad: state_d = vlmra_pkg::StOut;
      vlmra_pkg::StOut: begin
        if (!out_stall_i) begin
          state_d = vlmra_pkg::StIdle;
        end
      end
      default: state_d = vlmra_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      vlmra_pkg::StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      vlmra_pkg::StExec: cmd_o.exec = 1'b1;
      vlmra_pkg::StLoad: cmd_o.load = 1'b1;
      vlmra_pkg::StOut:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/vlmra_dp.sv =====
// Datapath of the message ring allocator: ring pointers, counters, peaks and
// the two header stores. Depends on vlmra_pkg and vlmra_ram.
module vlmra_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vlmra_pkg::ctrl_cmd_t cmd_i,
  output vlmra_pkg::ctrl_sts_t sts_o,
  input  vlmra_pkg::in_t       in_req_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  output vlmra_pkg::out_t      out_rsp_o
);

  localparam int OffW = vlmra_pkg::OffW;
  localparam int PosW = vlmra_pkg::PosW;
  localparam int LenW = vlmra_pkg::LenW;

  vlmra_pkg::in_t item_q;

  logic [OffW-1:0] oldest_q, oldest_d, newest_q, newest_d;
  logic            empty_q, empty_d;
  logic [7:0]      old_type_q, old_type_d;
  logic [LenW-1:0] old_len_q, old_len_d, new_len_q, new_len_d;
  logic [5:0]      pend_q, pend_d, ppeak_q, ppeak_d;
  logic [7:0]      used_q, used_d, upeak_q, upeak_d, miss_q, miss_d;
  logic            ok_q, ok_d;
  logic [6:0]      where_q, where_d;
  logic [7:0]      noev_q;

  logic               meta_we, next_we;
  vlmra_pkg::meta_t   meta_wdata, meta_rdata;
  logic [OffW-1:0]    next_rdata;

  logic [LenW-1:0] need;
  logic [PosW-1:0] need_w, end_excl, oldest_w, room, where_sum, oldest_sum;
  logic            wrapped, fits_tail, fits_head, add_ok;
  logic [OffW-1:0] start;
  logic [5:0]      pend_inc;
  logic [7:0]      used_inc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      newest_q <= '0;
      empty_q  <= 1'b1;
      pend_q   <= '0;
      used_q   <= '0;
      ppeak_q  <= '0;
      upeak_q  <= '0;
      miss_q   <= '0;
      ok_q     <= 1'b0;
      where_q  <= '0;
      noev_q   <= '0;
    end else begin
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      empty_q  <= empty_d;
      pend_q   <= pend_d;
      used_q   <= used_d;
      ppeak_q  <= ppeak_d;
      upeak_q  <= upeak_d;
      miss_q   <= miss_d;
      ok_q     <= ok_d;
      where_q  <= where_d;
      if (cfg_we_i) begin
        noev_q <= cfg_data_i;
      end
    end
  end

  // Header fields of the oldest and newest messages, mirrored out of the stores.
  always_ff @(posedge clk_i) begin
    old_type_q <= old_type_d;
    old_len_q  <= old_len_d;
    new_len_q  <= new_len_d;
  end

  // First fit: after the newest message, else wrap to offset 0.
  always_comb begin
    need     = LenW'(item_q.payload_bytes) + LenW'(vlmra_pkg::HdrBytes);
    need_w   = PosW'(need);
    end_excl = PosW'(newest_q) + PosW'(new_len_q);
    oldest_w = PosW'(oldest_q);
    wrapped  = oldest_w >= end_excl;
    if (wrapped) begin
      room = oldest_w - end_excl;
    end else if (end_excl >= PosW'(vlmra_pkg::BufferBytes)) begin
      room = '0;
    end else begin
      room = PosW'(vlmra_pkg::BufferBytes) - end_excl;
    end
    fits_tail = room >= need_w;
    fits_head = !wrapped && (oldest_w >= need_w);
    if (empty_q) begin
      add_ok = need_w <= PosW'(vlmra_pkg::BufferBytes);
      start  = '0;
    end else begin
      add_ok = fits_tail || fits_head;
      start  = fits_tail ? end_excl[OffW-1:0] : '0;
    end
    where_sum  = PosW'(start) + PosW'(vlmra_pkg::HdrBytes);
    oldest_sum = PosW'(oldest_q) + PosW'(vlmra_pkg::HdrBytes);
    pend_inc   = pend_q + 6'd1;
    used_inc   = used_q + 8'(need);
  end

  always_comb begin
    oldest_d   = oldest_q;
    newest_d   = newest_q;
    empty_d    = empty_q;
    old_type_d = old_type_q;
    old_len_d  = old_len_q;
    new_len_d  = new_len_q;
    pend_d     = pend_q;
    used_d     = used_q;
    ppeak_d    = ppeak_q;
    upeak_d    = upeak_q;
    miss_d     = miss_q;
    ok_d       = ok_q;
    where_d    = where_q;
    meta_we    = 1'b0;
    next_we    = 1'b0;
    meta_wdata = '{msg_type: item_q.event_type, length: need};

    if (cmd_i.exec) begin
      ok_d    = 1'b0;
      where_d = '0;
      case (item_q.operation)
        vlmra_pkg::OpAdd: begin
          if (add_ok) begin
            meta_we   = 1'b1;
            next_we   = !empty_q;
            newest_d  = start;
            new_len_d = need;
            if (empty_q) begin
              oldest_d   = '0;
              old_type_d = item_q.event_type;
              old_len_d  = need;
            end
            empty_d = 1'b0;
            pend_d  = pend_inc;
            used_d  = used_inc;
            if (pend_inc > ppeak_q) begin
              ppeak_d = pend_inc;
            end
            if (used_inc > upeak_q) begin
              upeak_d = used_inc;
            end
            ok_d    = 1'b1;
            where_d = where_sum[6:0];
          end else begin
            miss_d = miss_q + 8'd1;
          end
        end
        vlmra_pkg::OpRemove: begin
          if (!empty_q) begin
            ok_d   = 1'b1;
            pend_d = pend_q - 6'd1;
            used_d = used_q - 8'(old_len_q);
            if (oldest_q == newest_q) begin
              empty_d  = 1'b1;
              oldest_d = '0;
              newest_d = '0;
            end
          end
        end
        default: ;
      endcase
    end

    // Advance to the next message once its link and header have been read.
    if (cmd_i.load) begin
      oldest_d   = next_rdata;
      old_type_d = meta_rdata.msg_type;
      old_len_d  = meta_rdata.length;
    end
  end

  assign sts_o.need_load = (item_q.operation == vlmra_pkg::OpRemove) && !empty_q
                           && (oldest_q != newest_q);

  // Link store is read at the oldest message; its output addresses the header.
  vlmra_ram #(
    .Width(OffW),
    .Depth(vlmra_pkg::BufferBytes)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (next_we),
    .waddr_i(newest_q),
    .wdata_i(start),
    .raddr_i(oldest_q),
    .rdata_o(next_rdata)
  );

  vlmra_ram #(
    .Width($bits(vlmra_pkg::meta_t)),
    .Depth(vlmra_pkg::BufferBytes)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(start),
    .wdata_i(meta_wdata),
    .raddr_i(next_rdata),
    .rdata_o(meta_rdata)
  );

  always_comb begin
    out_rsp_o.ok                    = ok_q;
    out_rsp_o.payload_offset        = where_q;
    out_rsp_o.oldest_payload_offset = empty_q ? 7'd0 : oldest_sum[6:0];
    out_rsp_o.active_type           = empty_q ? noev_q : old_type_q;
    out_rsp_o.queue_empty           = empty_q;
    out_rsp_o.pending_count         = pend_q;
    out_rsp_o.bytes_used            = used_q;
    out_rsp_o.peak_pending          = ppeak_q;
    out_rsp_o.peak_bytes_used       = upeak_q;
    out_rsp_o.missed_count          = miss_q;
  end

endmodule

// ===== hw/rtl/variable_length_message_ring_alloc_top.sv =====
// Variable-length message ring allocator, top level.
// Instantiates vlmra_ctrl and vlmra_dp; types and constants from vlmra_pkg.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_req_i): add a message,
//   remove the oldest one, or query status. Each request yields exactly one
//   result on the result channel (out_valid_o / out_stall_i / out_rsp_o):
//   ok flag, new payload offset, oldest message, counts, peaks, misses.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
//   event code reported while no message is pending; write it while idle.
// Timing:
//   One request at a time. After acceptance the request passes the read and
//   execute states, then the result state (a remove that leaves messages
//   pending also passes the load state: the link store is read, then the
//   header of the next message). A new request is taken in the cycle after
//   the result is taken.
// Reset:
//   Ring empty, counters, peaks and misses zero, event code zero; header
//   stores are not cleared, no clearing pass. While out_stall_i is high the
//   result holds and in_stall_o stays high.
module variable_length_message_ring_alloc_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vlmra_pkg::in_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vlmra_pkg::out_t out_rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_data_i
);

  vlmra_pkg::ctrl_cmd_t cmd;
  vlmra_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vlmra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  vlmra_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_req_i  (in_req_i),
    .cfg_we_i  (cfg_valid_i & cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .out_rsp_o (out_rsp_o)
  );

  // A request never produces its result in the cycle right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result valid too early after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.queue_empty) |-> (out_rsp_o.pending_count == 6'd0)
      && (out_rsp_o.bytes_used == 8'd0))
    else $error("empty ring reports pending messages");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.peak_bytes_used >= out_rsp_o.bytes_used)
      && (out_rsp_o.peak_pending >= out_rsp_o.pending_count))
    else $error("peak below current value");

endmodule

// ===== bench/variable_length_message_ring_alloc_top_tb.sv =====
// Self-checking bench for variable_length_message_ring_alloc_top: a ring occupancy
// predictor in a small scoreboard class, request/result drivers with random idling.
// Depends on vlmra_pkg for the request/result structs, sizes and operation codes.
module variable_length_message_ring_alloc_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         PhaseItems = 530;
  localparam int         QuietLimit = 4000;
  localparam int         LongHold   = 400;
  localparam int         ReportMax  = 10;

  class ring_scoreboard;
    logic [7:0]  idle_code;
    int unsigned head_pos;
    int unsigned tail_pos;
    bit          ring_empty;
    logic [7:0]  hdr_type [vlmra_pkg::BufferBytes];
    logic [7:0]  hdr_len [vlmra_pkg::BufferBytes];
    int unsigned hdr_next [vlmra_pkg::BufferBytes];
    logic [5:0]  msg_count;
    logic [5:0]  msg_peak;
    logic [7:0]  byte_count;
    logic [7:0]  byte_peak;
    logic [7:0]  refused;
    vlmra_pkg::out_t expected_q[$];
    int unsigned mismatches;

    function new();
      idle_code  = '0;
      head_pos   = 0;
      tail_pos   = 0;
      ring_empty = 1'b1;
      msg_count  = '0;
      msg_peak   = '0;
      byte_count = '0;
      byte_peak  = '0;
      refused    = '0;
      mismatches = 0;
      for (int i = 0; i < vlmra_pkg::BufferBytes; i++) begin
        hdr_type[i] = '0;
        hdr_len[i]  = '0;
        hdr_next[i] = 0;
      end
    endfunction

    function void set_code(logic [7:0] code);
      idle_code = code;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // First fit: after the newest message, else at offset 0 ahead of the oldest.
    function bit place_message(logic [7:0] typ, logic [6:0] size, output int unsigned at);
      int unsigned need;
      int unsigned start;
      int unsigned end_excl;
      int unsigned room;
      bit          wrapped;
      at   = 0;
      need = int'(size) + vlmra_pkg::HdrBytes;
      if (ring_empty) begin
        if (vlmra_pkg::BufferBytes < need) return 1'b0;
        start    = 0;
        head_pos = 0;
      end else begin
        end_excl = tail_pos + hdr_len[tail_pos];
        wrapped  = head_pos > end_excl - 1;
        if (wrapped) room = head_pos - end_excl;
        else room = (end_excl >= vlmra_pkg::BufferBytes) ? 0
                  : vlmra_pkg::BufferBytes - end_excl;
        if (room >= need) start = end_excl;
        else if (!wrapped && head_pos >= need) start = 0;
        else return 1'b0;
        hdr_next[tail_pos] = start;
      end
      start           = start % vlmra_pkg::BufferBytes;
      hdr_type[start] = typ;
      hdr_len[start]  = 8'(need);
      hdr_next[start] = 0;
      tail_pos        = start;
      ring_empty      = 1'b0;
      msg_count       = msg_count + 6'd1;
      if (msg_count > msg_peak) msg_peak = msg_count;
      byte_count = byte_count + 8'(need);
      if (byte_count > byte_peak) byte_peak = byte_count;
      at = start + vlmra_pkg::HdrBytes;
      return 1'b1;
    endfunction

    function bit release_oldest();
      if (ring_empty) return 1'b0;
      msg_count  = msg_count - 6'd1;
      byte_count = byte_count - hdr_len[head_pos];
      if (head_pos == tail_pos) begin
        ring_empty = 1'b1;
        head_pos   = 0;
        tail_pos   = 0;
      end else begin
        head_pos = hdr_next[head_pos] % vlmra_pkg::BufferBytes;
      end
      return 1'b1;
    endfunction

    function void note_request(vlmra_pkg::in_t req);
      vlmra_pkg::out_t exp;
      int unsigned     at;
      bit              done;
      exp  = '0;
      at   = 0;
      done = 1'b0;
      case (req.operation)
        vlmra_pkg::OpAdd: begin
          done = place_message(req.event_type, req.payload_bytes, at);
          if (!done) begin
            refused = refused + 8'd1;
            at      = 0;
          end
        end
        vlmra_pkg::OpRemove: done = release_oldest();
        default: ;
      endcase
      exp.ok             = done;
      exp.payload_offset = 7'(at);
      if (ring_empty) begin
        exp.oldest_payload_offset = '0;
        exp.active_type           = idle_code;
        exp.queue_empty           = 1'b1;
      end else begin
        exp.oldest_payload_offset = 7'(head_pos + vlmra_pkg::HdrBytes);
        exp.active_type           = hdr_type[head_pos];
        exp.queue_empty           = 1'b0;
      end
      exp.pending_count   = msg_count;
      exp.bytes_used      = byte_count;
      exp.peak_pending    = msg_peak;
      exp.peak_bytes_used = byte_peak;
      exp.missed_count    = refused;
      expected_q.push_back(exp);
    endfunction

    function void check_result(vlmra_pkg::out_t got);
      vlmra_pkg::out_t exp;
      string           diff;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) $display("unexpected result %p", got);
        return;
      end
      exp  = expected_q.pop_front();
      diff = "";
      if (got.ok !== exp.ok)
        diff = {diff, $sformatf(" ok %0d/%0d", exp.ok, got.ok)};
      if (got.payload_offset !== exp.payload_offset)
        diff = {diff, $sformatf(" payload_offset %0d/%0d", exp.payload_offset,
                                got.payload_offset)};
      if (got.oldest_payload_offset !== exp.oldest_payload_offset)
        diff = {diff, $sformatf(" oldest_payload_offset %0d/%0d",
                                exp.oldest_payload_offset, got.oldest_payload_offset)};
      if (got.active_type !== exp.active_type)
        diff = {diff, $sformatf(" active_type %0h/%0h", exp.active_type, got.active_type)};
      if (got.queue_empty !== exp.queue_empty)
        diff = {diff, $sformatf(" queue_empty %0d/%0d", exp.queue_empty, got.queue_empty)};
      if (got.pending_count !== exp.pending_count)
        diff = {diff, $sformatf(" pending_count %0d/%0d", exp.pending_count,
                                got.pending_count)};
      if (got.bytes_used !== exp.bytes_used)
        diff = {diff, $sformatf(" bytes_used %0d/%0d", exp.bytes_used, got.bytes_used)};
      if (got.peak_pending !== exp.peak_pending)
        diff = {diff, $sformatf(" peak_pending %0d/%0d", exp.peak_pending,
                                got.peak_pending)};
      if (got.peak_bytes_used !== exp.peak_bytes_used)
        diff = {diff, $sformatf(" peak_bytes_used %0d/%0d", exp.peak_bytes_used,
                                got.peak_bytes_used)};
      if (got.missed_count !== exp.missed_count)
        diff = {diff, $sformatf(" missed_count %0d/%0d", exp.missed_count,
                                got.missed_count)};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= ReportMax) $display("result mismatch (expected/actual):%s", diff);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  vlmra_pkg::in_t  in_req_i;
  logic            out_valid_o;
  logic            out_stall_i;
  vlmra_pkg::out_t out_rsp_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [7:0]      cfg_data_i;

  ring_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  variable_length_message_ring_alloc_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Receiver: random stalls, or a long hold-off when armed.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request; keep valid high when no idle cycle is drawn.
  task automatic issue(logic [1:0] op, logic [7:0] typ, logic [6:0] size);
    vlmra_pkg::in_t req;
    req.operation     = op;
    req.event_type    = typ;
    req.payload_bytes = size;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_code(logic [7:0] code);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_code(code);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Bias the mix toward filling or draining so the ring both fills and wraps.
  task automatic random_request(int add_pct);
    int         roll;
    int         pick;
    logic [1:0] op;
    logic [6:0] size;
    roll = $urandom_range(99);
    if (roll < add_pct) op = vlmra_pkg::OpAdd;
    else if (roll < 90) op = vlmra_pkg::OpRemove;
    else if (roll < 98) op = vlmra_pkg::OpQuery;
    else op = OpUnused;
    pick = $urandom_range(9);
    if (pick < 7) size = 7'($urandom_range(15));
    else if (pick < 9) size = 7'($urandom_range(60, 16));
    else size = 7'($urandom_range(127));
    issue(op, 8'($urandom_range(255)), size);
  endtask

  initial begin
    logic [7:0] phase_code [3];
    int         add_pct;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    send_idle_pct  = 11;
    recv_stall_pct = 50;
    hold_left      = 0;
    quiet_cycles   = 0;
    phase_code[0]  = 8'h00;
    phase_code[1]  = 8'($urandom_range(254, 1));
    phase_code[2]  = 8'h80;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_code(8'hFF);
    issue(vlmra_pkg::OpQuery, 8'h00, 7'd0);
    issue(vlmra_pkg::OpRemove, 8'h11, 7'd0);   // remove on an empty ring
    issue(OpUnused, 8'hFF, 7'h7F);
    issue(vlmra_pkg::OpAdd, 8'h3C, 7'd127);    // larger than the ring: refused
    issue(vlmra_pkg::OpAdd, 8'hFF, 7'd124);    // fills the ring exactly
    issue(vlmra_pkg::OpAdd, 8'h01, 7'd0);      // refused when full
    issue(vlmra_pkg::OpQuery, 8'h00, 7'd0);
    issue(vlmra_pkg::OpRemove, 8'h00, 7'd0);
    issue(vlmra_pkg::OpAdd, 8'hA5, 7'd120);
    issue(vlmra_pkg::OpAdd, 8'h00, 7'd0);      // header in the last 4 bytes, offset wraps to 0
    issue(vlmra_pkg::OpQuery, 8'h00, 7'd0);
    issue(vlmra_pkg::OpRemove, 8'h00, 7'd0);
    issue(vlmra_pkg::OpAdd, 8'h7E, 7'd3);      // tail full: wrap to offset 0
    issue(vlmra_pkg::OpAdd, 8'h81, 7'd100);
    issue(vlmra_pkg::OpAdd, 8'h42, 7'd20);     // gap in front of the oldest too small
    issue(vlmra_pkg::OpAdd, 8'h43, 7'd9);      // gap filled exactly
    repeat (5) issue(vlmra_pkg::OpRemove, 8'h00, 7'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 50 : 0;
      recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 11 : 0;
      write_code(phase_code[phase]);
      // Hold the result side off while requests keep coming.
      if (phase == 2) hold_left = LongHold;
      add_pct = 50;
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 40 == 0) begin
          case ($urandom_range(2))
            0: add_pct = 75;
            1: add_pct = 20;
            default: add_pct = 50;
          endcase
        end
        random_request(add_pct);
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
